// ----- hw/rtl/srsbk_pkg.sv -----
// ----------------------------------------------------------------------------
// srsbk_pkg
// types and constants shared by the stable record sorter
// ----------------------------------------------------------------------------
package srsbk_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned TOTAL_W = 32;

	// incoming record word
	typedef struct packed {
		logic [KEY_W-1:0]   frame_number;
		logic [TOTAL_W-1:0] red_total;
		logic               last;
	} rec_word_t;

	// sorted result word
	typedef struct packed {
		logic [KEY_W-1:0]   sorted_frame_number;
		logic [TOTAL_W-1:0] sorted_red_total;
		logic               last_out;
		logic               overflow;
	} srt_word_t;

	// one store entry
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TOTAL_W-1:0] total;
	} entry_t;

endpackage

// ----- hw/rtl/stable_record_sort_by_key.sv -----
// ----------------------------------------------------------------------------
// stable_record_sort_by_key
// stable insertion sort of key/payload records, sorted run emitted on last
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------------
//  rec     | in        | rec_valid / rec_ready | rec_word_t  (key, total, last)
//  srt     | out       | srt_valid / srt_ready | srt_word_t  (key, total, flags)
//
//  a record stored at p places before the end walks down from the tail: one
//  compare-and-shift step per cycle through the single store read port;
//  a dropped record goes straight back to idle, or to the run on last
//  a sorted run loads and emits each word in turn, waiting out any srt stall
//  rec_ready is high only while idle; no new record is taken during a run
//  reset clears the entry count and overflow flag; the store needs no clearing
//  since only the first count entries are ever read
//
module stable_record_sort_by_key
	import srsbk_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	output logic      rec_ready,
	input  rec_word_t rec,
	output logic      srt_valid,
	input  logic      srt_ready,
	output srt_word_t srt
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PLACE,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [IDX_W-1:0] pos_q;    // hole position during the insertion walk
	logic [IDX_W-1:0] idx_q;    // read position during the output run
	entry_t           new_q;    // record being inserted
	logic             last_q;
	srt_word_t        srt_q;
	logic             srt_valid_q;

	// sorted store, one write and one registered read per cycle
	entry_t           mem_q [DEPTH];
	entry_t           rd_q;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	logic             rec_acc;
	logic             srt_acc;
	logic             full;
	logic             shift;
	logic             run_end;
	logic [IDX_W-1:0] pos_m1;
	logic [IDX_W-1:0] pos_m2;
	logic [IDX_W-1:0] cnt_m1;
	logic [IDX_W-1:0] idx_p1;

	assign rec_ready = (state_q == ST_IDLE);
	assign rec_acc   = rec_valid && rec_ready;
	assign srt_valid = srt_valid_q;
	assign srt       = srt_q;
	assign srt_acc   = srt_valid_q && srt_ready;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign pos_m1  = pos_q - IDX_W'(1);
	assign pos_m2  = pos_m1 - IDX_W'(1);
	assign cnt_m1  = IDX_W'(count_q - CNT_W'(1));
	assign idx_p1  = idx_q + IDX_W'(1);
	// strict greater-than keeps equal keys in arrival order
	assign shift   = (rd_q.key > new_q.key);
	assign run_end = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// store port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = new_q;
		rd_en   = 1'b0;
		rd_addr = pos_m1;
		case (state_q)
			ST_IDLE: begin
				// look at the current tail entry right away
				rd_en   = rec_acc && !full && (count_q != '0);
				rd_addr = cnt_m1;
			end
			ST_CMP: begin
				wr_en = 1'b1;
				if (shift) begin
					// move the larger entry up one slot, fetch the next one down
					wr_data = rd_q;
					rd_en   = (pos_q > IDX_W'(1));
					rd_addr = pos_m2;
				end
			end
			ST_PLACE: begin
				wr_en = 1'b1;
			end
			ST_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
			end
			ST_EMIT_OUT: begin
				rd_en   = srt_acc && !srt_q.last_out;
				rd_addr = idx_p1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			srt_valid_q <= 1'b0;
			pos_q       <= '0;
			idx_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rec_acc) begin
						new_q.key   <= rec.frame_number;
						new_q.total <= rec.red_total;
						last_q      <= rec.last;
						idx_q       <= '0;
						if (full) begin
							// store full: drop the record, a last still flushes
							ovf_q   <= 1'b1;
							state_q <= rec.last ? ST_EMIT_RD : ST_IDLE;
						end else begin
							pos_q   <= IDX_W'(count_q);
							state_q <= (count_q == '0) ? ST_PLACE : ST_CMP;
						end
					end
				end
				ST_CMP: begin
					if (shift) begin
						pos_q <= pos_m1;
						if (pos_q == IDX_W'(1)) begin
							state_q <= ST_PLACE;
						end
					end else begin
						// new record written into the hole this cycle
						count_q <= count_q + CNT_W'(1);
						state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					srt_q.sorted_frame_number <= rd_q.key;
					srt_q.sorted_red_total    <= rd_q.total;
					srt_q.last_out            <= run_end;
					srt_q.overflow            <= ovf_q;
					srt_valid_q               <= 1'b1;
					state_q                   <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (srt_acc) begin
						srt_valid_q <= 1'b0;
						if (srt_q.last_out) begin
							// run done, store empties
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_p1;
							state_q <= ST_EMIT_LD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input is never taken while a sorted word is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_ready && srt_valid))
		else $error("record accepted during sorted run");

	// entry count never exceeds the store depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	// the insertion hole stays between 1 and the entry count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (CNT_W'(pos_q) <= count_q) && (pos_q != '0))
		else $error("insertion position out of range");

	// the final word of a run empties the store
	assert property (@(posedge clk) disable iff (!arst_n)
		(srt_acc && srt.last_out) |=> (count_q == '0) && !ovf_q && rec_ready)
		else $error("store not emptied after run");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the stable record sorter against its own sorted-store predictor:
// records go in on the rec channel, each sorted run coming back on srt is
// matched word by word against the predicted run, across phases of source
// idling and sink stalling
// ----------------------------------------------------------------------------
module tb
	import srsbk_pkg::*;
();

	localparam int unsigned DEPTH       = 64;
	// longest quiet stretch is the long sink hold plus one full insertion walk
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 20;
	localparam int unsigned PHASE_RECS  = 18;

	typedef enum int {
		PH_FREE,
		PH_SRC_IDLE,
		PH_SNK_STALL,
		PH_BOTH
	} phase_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      rec_valid = 1'b0;
	logic      rec_ready;
	rec_word_t rec       = '0;
	logic      srt_valid;
	logic      srt_ready = 1'b0;
	srt_word_t srt;

	stable_record_sort_by_key #(
		.DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec      (rec),
		.srt_valid(srt_valid),
		.srt_ready(srt_ready),
		.srt      (srt)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state: the sorted store as the block should hold it
	entry_t      held [DEPTH];
	int unsigned held_cnt     = 0;
	bit          held_dropped = 1'b0;

	// sorted words still owed by the block, oldest first
	srt_word_t   sorted_q [$];
	// records waiting for the driver
	rec_word_t   pend_q [$];

	int unsigned n_pushed     = 0;
	int unsigned n_taken      = 0;
	int unsigned n_err        = 0;
	int unsigned quiet_cycles = 0;

	// traffic shaping, written by the sequencer at rising edges only
	phase_t      phase         = PH_FREE;
	int unsigned src_idle_pct  = 0;
	int unsigned snk_stall_pct = 0;

	logic        rec_hs    = 1'b0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	// insert one accepted record; on last, queue the whole sorted run
	function automatic void file_record(input rec_word_t w);
		int unsigned p;
		int unsigned k;
		srt_word_t   r;
		if (held_cnt >= DEPTH) begin
			// store full: record lost, run gets flagged
			held_dropped = 1'b1;
		end else begin
			p = held_cnt;
			// strict greater-than keeps equal keys in arrival order
			while (p > 0 && held[p-1].key > w.frame_number) begin
				held[p] = held[p-1];
				p--;
			end
			held[p].key   = w.frame_number;
			held[p].total = w.red_total;
			held_cnt++;
		end
		if (w.last) begin
			for (k = 0; k < held_cnt; k++) begin
				r.sorted_frame_number = held[k].key;
				r.sorted_red_total    = held[k].total;
				r.last_out            = (k + 1 == held_cnt);
				r.overflow            = held_dropped;
				sorted_q = {sorted_q, r};
			end
			held_cnt     = 0;
			held_dropped = 1'b0;
		end
	endfunction

	function automatic void push_rec(input logic [31:0] key, input logic [31:0] total,
		input logic last);
		rec_word_t w;
		w.frame_number = key;
		w.red_total    = total;
		w.last         = last;
		pend_q = {pend_q, w};
		n_pushed++;
	endfunction

	// keys lean toward a few values at both ends of the range so equal keys are common
	function automatic logic [31:0] pick_key();
		logic [31:0] key;
		case ($urandom_range(3))
			0: key = $urandom_range(3);
			1: key = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(2) : $urandom_range(2);
			default: key = $urandom();
		endcase
		return key;
	endfunction

	function automatic void push_batch(input int unsigned n);
		int unsigned k;
		for (k = 0; k < n; k++)
			push_rec(pick_key(), $urandom(), k == n - 1);
	endfunction

	function automatic void cmp_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			n_err++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// record driver: new word at the falling edge once the last one went in
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
		end else if (!rec_valid || rec_hs) begin
			if (pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				rec       <= pend_q.pop_front();
				rec_valid <= 1'b1;
			end else begin
				rec_valid <= 1'b0;
			end
		end
		rec_hs <= 1'b0;
	end

	// ------------------------------------------------------------------------
	// sink ready: random stalls, plus one long hold on the first run so the
	// block backs up and the driver sits on a pending record
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			srt_ready <= 1'b0;
		end else if (hold_left != 0) begin
			srt_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && phase == PH_FREE && srt_valid) begin
			srt_ready <= 1'b0;
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else begin
			srt_ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// handshake sampling at the rising edge: predict on record words, check
	// sorted words, and watch for a hang
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : sample
		srt_word_t want_w;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (rec_valid && rec_ready) begin
				file_record(rec);
				n_taken++;
				rec_hs <= 1'b1;
				moved = 1'b1;
			end
			if (srt_valid && srt_ready) begin
				moved = 1'b1;
				if (sorted_q.size() == 0) begin
					$display("%0t ns: unexpected sorted word, expected none, got %p",
						$time, srt);
					n_err++;
				end else begin
					want_w = sorted_q.pop_front();
					cmp_field("sorted_frame_number", want_w.sorted_frame_number,
						srt.sorted_frame_number);
					cmp_field("sorted_red_total", want_w.sorted_red_total,
						srt.sorted_red_total);
					cmp_field("last_out", want_w.last_out, srt.last_out);
					cmp_field("overflow", want_w.overflow, srt.overflow);
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no word moved for %0d cycles", $time, quiet_cycles);
				$display("** stable_record_sort_by_key: FAILED **");
				$finish;
			end
		end
	end

	// sender pause: every record taken and every sorted word back
	task automatic wait_drain();
		while (!(n_taken == n_pushed && sorted_q.size() == 0))
			@(posedge clk);
	endtask

	task automatic run_phase(input phase_t ph, input int unsigned src_pct,
		input int unsigned snk_pct);
		int unsigned start;
		@(posedge clk);
		phase         = ph;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		start         = n_pushed;
		while (n_pushed - start < PHASE_RECS)
			push_batch($urandom_range(1, 8));
		wait_drain();
	endtask

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	initial begin : seq
		int unsigned k;

		// single-record runs at both key extremes
		push_rec(32'h0000_0000, 32'h0000_0000, 1'b1);
		push_rec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// equal keys interleaved with others: arrival order must survive
		push_rec(32'd5, 32'h0000_0001, 1'b0);
		push_rec(32'd3, 32'h0000_0010, 1'b0);
		push_rec(32'd5, 32'h0000_0002, 1'b0);
		push_rec(32'd7, 32'h0000_0020, 1'b0);
		push_rec(32'd5, 32'h0000_0003, 1'b1);
		// strictly descending, alternating bit patterns
		push_rec(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		push_rec(32'h8000_0000, 32'hAAAA_AAAA, 1'b0);
		push_rec(32'h5555_5555, 32'h5555_5555, 1'b0);
		push_rec(32'h0000_0001, 32'h8000_0001, 1'b0);
		push_rec(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		// already ascending with duplicates, no shifting at all
		push_rec(32'd0, 32'h1234_5678, 1'b0);
		push_rec(32'd0, 32'h9ABC_DEF0, 1'b0);
		push_rec(32'd1, 32'h0F0F_0F0F, 1'b0);
		push_rec(32'd1, 32'hF0F0_F0F0, 1'b1);
		// store overflow: fill every entry, drop two more, the last of them
		// being the dropped record that still starts the run
		for (k = 0; k < DEPTH + 2; k++)
			push_rec(pick_key(), $urandom(), k == DEPTH + 1);

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		run_phase(PH_FREE, 0, 0);
		run_phase(PH_SRC_IDLE, 78, 0);
		run_phase(PH_SNK_STALL, 0, 78);
		run_phase(PH_BOTH, 21, 21);

		// anything trailing the last run is caught as unexpected
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sorted_q.size() != 0)
			$display("%0t ns: %0d sorted words never arrived", $time, sorted_q.size());
		if (n_err == 0 && sorted_q.size() == 0) begin
			$display("** stable_record_sort_by_key: PASSED **");
		end else begin
			$display("** stable_record_sort_by_key: FAILED **");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/srsbk_pkg.sv
hw/rtl/stable_record_sort_by_key.sv
verif/tb.sv
